// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/blepc_pkg.sv
// Package for the BLE pairing crypto block: opcodes, command/status types, AES helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package blepc_pkg;
    localparam logic [2:0] OP_C1 = 3'd0;
    localparam logic [2:0] OP_S1 = 3'd1;
    localparam logic [2:0] OP_AH = 3'd2;
    localparam logic [2:0] OP_D1 = 3'd3;
    localparam logic [2:0] OP_DM = 3'd4;
    localparam int ROUNDS = 10;

    typedef struct packed {
        logic load;     // capture the item and start the first pass
        logic pass2;    // start the second c1 pass
        logic round;    // run one AES round
        logic finish;   // format the result
    } t_cmd;

    typedef struct packed {
        logic last_round;
        logic is_c1;
        logic bad_op;
    } t_status;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits at bits [127-8i -: 8]
    function automatic logic [7:0] byte_at(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction
endpackage

// File: hw/rtl/blepc_ctrl.sv
// Controller FSM of the BLE pairing crypto block: sequences load, rounds, passes, output.
// Depends on blepc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module blepc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  blepc_pkg::t_status  i_status,
    output blepc_pkg::t_cmd     o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;
    t_state r_state;
    logic   r_second;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.round  = (r_state == S_RUN);
        o_cmd.pass2  = (r_state == S_RUN) && i_status.last_round && i_status.is_c1 && !r_second;
        o_cmd.finish = (r_state == S_RUN) && i_status.last_round && !o_cmd.pass2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_second <= 1'b0;
                        // unused opcodes skip the cipher
                        r_state  <= i_status.bad_op ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_cmd.pass2) r_second <= 1'b1;
                    if (o_cmd.finish) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `ASSERT_NEXT(a_finish_done, i_clk, i_rst_n, o_cmd.finish, o_out_valid)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
endmodule

// File: hw/rtl/blepc_datapath.sv
// Datapath of the BLE pairing crypto block: operand build, one AES round per cycle, output format.
// Depends on blepc_pkg.
`timescale 1ns / 1ps
module blepc_datapath (
    input  logic                i_clk,
    input  blepc_pkg::t_cmd     i_cmd,
    input  logic [2:0]          i_opcode,
    input  logic [63:0]         i_key_lo,
    input  logic [63:0]         i_key_hi,
    input  logic [63:0]         i_rand_lo,
    input  logic [63:0]         i_rand_hi,
    input  logic [55:0]         i_pair_request,
    input  logic [55:0]         i_pair_response,
    input  logic                i_init_addr_type,
    input  logic                i_resp_addr_type,
    input  logic [47:0]         i_init_addr,
    input  logic [47:0]         i_resp_addr,
    input  logic [15:0]         i_diversifier,
    output blepc_pkg::t_status  o_status,
    output logic [127:0]        o_result
);
    logic [127:0] r_state, r_key, r_key0, r_p2, r_result;
    logic [2:0]   r_op;
    logic [3:0]   r_round;
    logic [7:0]   r_rcon;
    logic [127:0] n_key, plain, round_out, sub, shr;
    logic [127:0] mix;
    logic [7:0]   g0, g1, g2, g3;
    logic [31:0]  w0, w1, w2, w3;

    assign o_status.last_round = (r_round == 4'(blepc_pkg::ROUNDS));
    assign o_status.is_c1      = (r_op == blepc_pkg::OP_C1);
    assign o_status.bad_op     = (i_opcode > blepc_pkg::OP_DM);
    assign o_result            = r_result;

    always_comb begin
        case (i_opcode)
            blepc_pkg::OP_C1: plain = {i_rand_hi, i_rand_lo}
                ^ {i_pair_response, i_pair_request, 7'd0, i_resp_addr_type,
                   7'd0, i_init_addr_type};
            blepc_pkg::OP_S1: plain = {i_rand_lo, i_rand_hi};
            blepc_pkg::OP_AH: plain = {104'd0, i_rand_lo[23:0]};
            blepc_pkg::OP_D1: plain = {96'd0, i_rand_lo[15:0], i_diversifier};
            default:          plain = {64'd0, i_rand_lo};
        endcase
    end

    // one round: sub bytes, shift rows, mix columns unless final, add next round key
    always_comb begin
        for (int i = 0; i < 16; i++)
            sub[127 - 8 * i -: 8] = blepc_pkg::sbox(blepc_pkg::byte_at(r_state, i));
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                shr[127 - 8 * (4 * c + r) -: 8] =
                    blepc_pkg::byte_at(sub, 4 * ((c + r) % 4) + r);
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = blepc_pkg::byte_at(shr, 4 * c);
            a1 = blepc_pkg::byte_at(shr, 4 * c + 1);
            a2 = blepc_pkg::byte_at(shr, 4 * c + 2);
            a3 = blepc_pkg::byte_at(shr, 4 * c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            mix[127 - 32 * c -: 32] = {a0 ^ al ^ blepc_pkg::xtime(a0 ^ a1),
                                       a1 ^ al ^ blepc_pkg::xtime(a1 ^ a2),
                                       a2 ^ al ^ blepc_pkg::xtime(a2 ^ a3),
                                       a3 ^ al ^ blepc_pkg::xtime(a3 ^ a0)};
        end
        g0 = blepc_pkg::sbox(blepc_pkg::byte_at(r_key, 13));
        g1 = blepc_pkg::sbox(blepc_pkg::byte_at(r_key, 14));
        g2 = blepc_pkg::sbox(blepc_pkg::byte_at(r_key, 15));
        g3 = blepc_pkg::sbox(blepc_pkg::byte_at(r_key, 12));
        w0 = r_key[127:96] ^ {g0 ^ r_rcon, g1, g2, g3};
        w1 = r_key[95:64] ^ w0;
        w2 = r_key[63:32] ^ w1;
        w3 = r_key[31:0] ^ w2;
        n_key = {w0, w1, w2, w3};
        round_out = (o_status.last_round ? shr : mix) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_key0  <= {i_key_hi, i_key_lo};
            r_key   <= {i_key_hi, i_key_lo};
            r_state <= plain ^ {i_key_hi, i_key_lo};
            r_p2    <= {32'd0, i_init_addr, i_resp_addr};
            r_round <= 4'd1;
            r_rcon  <= 8'h01;
            r_result <= '0;
        end else if (i_cmd.pass2) begin
            r_key   <= r_key0;
            r_state <= round_out ^ r_p2 ^ r_key0;
            r_round <= 4'd1;
            r_rcon  <= 8'h01;
        end else if (i_cmd.round) begin
            r_key   <= n_key;
            r_state <= round_out;
            r_round <= r_round + 4'd1;
            r_rcon  <= blepc_pkg::xtime(r_rcon);
        end
        if (i_cmd.finish) begin
            case (r_op)
                blepc_pkg::OP_S1: begin
                    for (int i = 0; i < 16; i++)
                        r_result[8 * i +: 8] <= round_out[127 - 8 * i -: 8];
                end
                blepc_pkg::OP_AH: r_result <= {104'd0, round_out[23:0]};
                blepc_pkg::OP_DM: r_result <= {112'd0, round_out[15:0]};
                default:          r_result <= round_out;
            endcase
        end
    end
endmodule

// File: hw/rtl/ble_pairing_crypto_functions.sv
// BLE legacy pairing security functions c1, s1, ah, d1, dm over an iterative AES-128.
// Each item runs one pass of AES rounds, c1 two passes; unused opcodes skip the cipher.
// A new item is accepted only once the previous result has been handed off and the
// controller is idle again.
// One AES round a cycle, key expanded on the fly in the same round unit.
// Reset (i_rst_n low, synchronous) returns the controller to idle; no result pending.
`timescale 1ns / 1ps
module ble_pairing_crypto_functions (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: key_lo 64, key_hi 64, rand_lo 64, rand_hi 64,
    // pair_request 56, pair_response 56, init_addr_type 1, resp_addr_type 1,
    // init_addr 48, resp_addr 48, diversifier 16, zero pad 6 (488 bits)
    input  logic [487:0] s_axis_tdata,
    // tuser: opcode 3
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: result_lo 64, result_hi 64
    output logic [127:0] m_axis_tdata
);
    blepc_pkg::t_cmd    cmd;
    blepc_pkg::t_status status;
    logic [127:0]       result;

    // accept only when idle; the controller holds the result until taken
    blepc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    blepc_datapath u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_opcode         (s_axis_tuser),
        .i_key_lo         (s_axis_tdata[63:0]),
        .i_key_hi         (s_axis_tdata[127:64]),
        .i_rand_lo        (s_axis_tdata[191:128]),
        .i_rand_hi        (s_axis_tdata[255:192]),
        .i_pair_request   (s_axis_tdata[311:256]),
        .i_pair_response  (s_axis_tdata[367:312]),
        .i_init_addr_type (s_axis_tdata[368]),
        .i_resp_addr_type (s_axis_tdata[369]),
        .i_init_addr      (s_axis_tdata[417:370]),
        .i_resp_addr      (s_axis_tdata[465:418]),
        .i_diversifier    (s_axis_tdata[481:466]),
        .o_status         (status),
        .o_result         (result)
    );

    // result register holds {hi, lo}, so lo lands in the low half directly
    assign m_axis_tdata = result;
endmodule

// File: sim/ble_pairing_crypto_functions_chk.sv
// Checker for the BLE pairing crypto block: watches both streams, predicts and compares.
// Depends on blepc_pkg for the opcode codes; keeps its own AES-128 model.
`timescale 1ns / 1ps
module ble_pairing_crypto_functions_chk (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [487:0] i_in_data,
    input  logic [2:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    output int           o_errors,
    output int           o_pending
);
    localparam logic [7:0] SUBST [0:255] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    logic [127:0] expected_results [$];

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] blk);
        logic [7:0] st [16];
        logic [7:0] rk [16];
        logic [7:0] tmp [16];
        logic [7:0] rcon;
        logic [7:0] a0, a1, a2, a3, mix, g0, g1, g2, g3;
        logic [127:0] res;
        rcon = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int i = 0; i < 16; i++) st[i] = SUBST[st[i]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) tmp[4 * c + r] = st[4 * ((c + r) % 4) + r];
            st = tmp;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    mix = a0 ^ a1 ^ a2 ^ a3;
                    st[4*c]   = a0 ^ mix ^ gf_double(a0 ^ a1);
                    st[4*c+1] = a1 ^ mix ^ gf_double(a1 ^ a2);
                    st[4*c+2] = a2 ^ mix ^ gf_double(a2 ^ a3);
                    st[4*c+3] = a3 ^ mix ^ gf_double(a3 ^ a0);
                end
            end
            g0 = SUBST[rk[13]]; g1 = SUBST[rk[14]]; g2 = SUBST[rk[15]]; g3 = SUBST[rk[12]];
            rk[0] ^= g0 ^ rcon; rk[1] ^= g1; rk[2] ^= g2; rk[3] ^= g3;
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
            rcon = gf_double(rcon);
            for (int i = 0; i < 16; i++) st[i] ^= rk[i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // Returns {result_hi, result_lo} for one command item.
    function automatic logic [127:0] pairing_result(input logic [2:0] op,
                                                    input logic [487:0] d);
        logic [127:0] key, rnd, p1, p2, t;
        logic [63:0]  rlo, rhi;
        logic [55:0]  preq, pres;
        logic         iat, rat;
        logic [47:0]  ia, ra;
        logic [15:0]  dv;
        key  = {d[127:64], d[63:0]};
        rlo  = d[191:128];
        rhi  = d[255:192];
        preq = d[311:256];
        pres = d[367:312];
        iat  = d[368];
        rat  = d[369];
        ia   = d[417:370];
        ra   = d[465:418];
        dv   = d[481:466];
        rnd  = {rhi, rlo};
        case (op)
            blepc_pkg::OP_C1: begin
                p1 = {pres, preq, 7'b0, rat, 7'b0, iat};
                p2 = {32'b0, ia, ra};
                t = aes_encrypt(key, rnd ^ p1);
                return aes_encrypt(key, t ^ p2);
            end
            blepc_pkg::OP_S1: begin
                t = aes_encrypt(key, {rlo, rhi});
                return {<<8{t}};
            end
            blepc_pkg::OP_AH: begin
                t = aes_encrypt(key, {104'b0, rlo[23:0]});
                return {104'b0, t[23:0]};
            end
            blepc_pkg::OP_D1: return aes_encrypt(key, {96'b0, rlo[15:0], dv});
            blepc_pkg::OP_DM: begin
                t = aes_encrypt(key, {64'b0, rlo});
                return {112'b0, t[15:0]};
            end
            default: return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        logic [127:0] want;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            expected_results.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(pairing_result(i_in_user, i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", i_out_data);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (want[63:0] !== i_out_data[63:0]) begin
                        $error("result_lo expected %h actual %h", want[63:0], i_out_data[63:0]);
                        errs++;
                    end
                    if (want[127:64] !== i_out_data[127:64]) begin
                        $error("result_hi expected %h actual %h",
                               want[127:64], i_out_data[127:64]);
                        errs++;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= expected_results.size();
        end
    end
endmodule

// File: sim/ble_pairing_crypto_functions_tb.sv
// Testbench top for the BLE pairing crypto block: clock, reset, stimulus and verdict.
// Depends on blepc_pkg, the block and ble_pairing_crypto_functions_chk.
`timescale 1ns / 1ps
module ble_pairing_crypto_functions_tb;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 600000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata, low bit up: key_lo, key_hi, rand_lo, rand_hi, pair_request, pair_response,
    // init_addr_type, resp_addr_type, init_addr, resp_addr, diversifier, zero pad
    logic [487:0] s_axis_tdata;
    // tuser: opcode
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata, low bit up: result_lo, result_hi
    logic [127:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count;

    ble_pairing_crypto_functions dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    ble_pairing_crypto_functions_chk checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_errors(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[ble_pairing_crypto_functions] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back up the block, then a clean stretch.
    initial begin
        int rx_cycles;
        rx_cycles = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles >= 3000 && rx_cycles < 3400)
                m_axis_tready <= 1'b0;
            else if (rx_cycles >= 12000 && rx_cycles < 20000)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 24);
        end
    end

    // Random 64-bit field, biased toward the all-zero and all-one extremes.
    function automatic logic [63:0] field64();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [487:0] random_payload();
        logic [487:0] d;
        logic [63:0]  f;
        d = '0;
        d[63:0]    = field64();
        d[127:64]  = field64();
        d[191:128] = field64();
        d[255:192] = field64();
        f = field64();
        d[311:256] = f[55:0];
        f = field64();
        d[367:312] = f[55:0];
        d[368]     = 1'($urandom_range(1));
        d[369]     = 1'($urandom_range(1));
        f = field64();
        d[417:370] = f[47:0];
        f = field64();
        d[465:418] = f[47:0];
        f = field64();
        d[481:466] = f[15:0];
        return d;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_command(input logic [2:0] op, input logic [487:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drop_valid(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    initial begin
        logic [2:0] op;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = blepc_pkg::OP_C1;
        i_rst_n       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every opcode with all-zero and all-one operands, then the unused codes.
        for (int k = 0; k < 8; k++) begin
            op = 3'(k);
            send_command(op, '0);
            send_command(op, {6'b0, {482{1'b1}}});
        end
        // Each function once with random content, address types mixed.
        send_command(blepc_pkg::OP_C1, random_payload());
        send_command(blepc_pkg::OP_S1, random_payload());
        send_command(blepc_pkg::OP_AH, random_payload());
        send_command(blepc_pkg::OP_D1, random_payload());
        send_command(blepc_pkg::OP_DM, random_payload());

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Let the block drain completely once, mid-run.
            if (n == 1000) begin
                drop_valid(1);
                while (pending != 0) @(negedge i_clk);
            end
            if ((n < 1200 || n >= 1500) && $urandom_range(99) < 24)
                drop_valid($urandom_range(1, 30));
            // Mostly real functions; an unused opcode now and then.
            if ($urandom_range(19) == 0)
                op = 3'($urandom_range(7, 5));
            else
                op = 3'($urandom_range(4));
            send_command(op, random_payload());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0)
            $display("[ble_pairing_crypto_functions] OK");
        else
            $display("[ble_pairing_crypto_functions] ERROR");
        $finish;
    end
endmodule
